// ===== rtl/pik_pkg.sv =====
// -----------------------------------------------------------------------------
// pik_pkg
// Types, widths and helpers shared by the pyramid index key unit.
// -----------------------------------------------------------------------------
`default_nettype none

package pik_pkg;

   localparam int MAX_DIMS      = 64;
   localparam int COORD_BITS    = 16;
   localparam int DIMS_BITS     = 7;
   localparam int COUNT_BITS    = 6;
   localparam int PYR_BITS      = 7;
   localparam int KEY_BITS      = 28;
   localparam int FRAC_BITS     = 8;
   localparam int SQUARE_BITS   = 2 * COORD_BITS;
   localparam int SUM_BITS      = SQUARE_BITS + COUNT_BITS;
   localparam int ROOT_BITS     = (SUM_BITS + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_BITS      = 2 * ROOT_BITS;
   localparam int REM_BITS      = ROOT_BITS + 3;
   localparam int STEP_BITS     = $clog2(ROOT_BITS);
   localparam int CSQRT_BITS    = 4;
   localparam int KEY_INT_BITS  = PYR_BITS + CSQRT_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [0:0] REG_DIMENSIONS = 1'b0;
   localparam logic [DIMS_BITS-1:0] DIMS_RESET = DIMS_BITS'(2);

   typedef struct packed {
      logic [COORD_BITS-1:0] center_coord;
      logic [COORD_BITS-1:0] point_coord;
   } req_payload_type;

   typedef struct packed {
      logic [PYR_BITS-1:0] pyramid_number;
      logic [KEY_BITS-1:0] key_fixed;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROOT,
      ST_DONE
   } state_type;

   // smallest r with r*r >= n, for n in 1..64
   function automatic logic [CSQRT_BITS-1:0] ceil_sqrt(input logic [DIMS_BITS-1:0] n);
      logic [CSQRT_BITS-1:0] r;
      begin
         if (n <= DIMS_BITS'(1))       r = CSQRT_BITS'(1);
         else if (n <= DIMS_BITS'(4))  r = CSQRT_BITS'(2);
         else if (n <= DIMS_BITS'(9))  r = CSQRT_BITS'(3);
         else if (n <= DIMS_BITS'(16)) r = CSQRT_BITS'(4);
         else if (n <= DIMS_BITS'(25)) r = CSQRT_BITS'(5);
         else if (n <= DIMS_BITS'(36)) r = CSQRT_BITS'(6);
         else if (n <= DIMS_BITS'(49)) r = CSQRT_BITS'(7);
         else                          r = CSQRT_BITS'(8);
         return r;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pyramid_index_key_unit.sv =====
// -----------------------------------------------------------------------------
// pyramid_index_key_unit
// Streams (center, point) coordinate pairs of one vector and returns the
// pyramid number and fixed point pyramid key after the last dimension.
// -----------------------------------------------------------------------------
//  channel  | ports                              | moves
//  ---------+------------------------------------+-------------------------------
//  req      | req_valid, req_ready, req_payload  | one coordinate pair per transaction
//  rsp      | rsp_valid, rsp_ready, rsp_payload  | pyramid number and key per vector
//  csr      | psel, penable, pwrite, paddr, ...  | dimensions register at address 0
//
//  a coordinate pair passes two states: capture and difference, then one shared
//  16x16 multiply-accumulate into the sum of squares.
//  the last pair of a vector then runs the bit-serial square root unit
//  (one root bit per cycle) and loads the result register.
//  the result register holds a finished transaction while the next vector
//  streams in; the unit only stalls when a new result is due and the old one
//  has not been taken. no clearing pass after reset.
`default_nettype none

module pyramid_index_key_unit
   import pik_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,

   input  wire                      req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_payload,

   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output rsp_payload_type          rsp_payload,

   input  wire                      psel,
   input  wire                      penable,
   input  wire                      pwrite,
   input  wire  [CSR_ADDR_BITS-1:0] paddr,
   input  wire  [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   state_type state_ff, state_in;

   logic [DIMS_BITS-1:0]    dims_ff, dims_in;
   logic [COUNT_BITS-1:0]   coord_count_ff, coord_count_in;
   logic [COORD_BITS-1:0]   max_abs_diff_ff, max_abs_diff_in;
   logic [COUNT_BITS-1:0]   max_index_ff, max_index_in;
   logic                    center_above_ff, center_above_in;
   logic [SUM_BITS-1:0]     sum_squares_ff, sum_squares_in;

   logic [COORD_BITS-1:0]   diff_ff, diff_in;
   logic                    last_ff, last_in;
   logic [PYR_BITS-1:0]     pyr_ff, pyr_in;
   logic [KEY_INT_BITS-1:0] key_int_ff, key_int_in;

   logic [RAD_BITS-1:0]     rad_ff, rad_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic [ROOT_BITS-1:0]    root_ff, root_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   // sequencer controls
   logic req_fire;
   logic mac_en;
   logic root_en;
   logic out_load;
   logic root_last;

   // per-item datapath
   logic [DIMS_BITS-1:0]    dims_eff;
   logic                    c_gt;
   logic [COORD_BITS-1:0]   diff;
   logic                    take;
   logic [COUNT_BITS-1:0]   new_index;
   logic                    new_above;
   logic                    is_last;
   logic [PYR_BITS-1:0]     pyr;
   logic [SQUARE_BITS-1:0]  square;
   logic [SUM_BITS-1:0]     sum_next;
   logic [REM_BITS-1:0]     rem_shift;
   logic [REM_BITS-1:0]     trial;
   logic                    trial_ok;
   logic [KEY_BITS-1:0]     key;
   logic                    csr_write;

   assign req_fire  = req_valid && req_ready;
   assign root_last = (step_ff == STEP_BITS'(ROOT_BITS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_MAC;
         end
         ST_MAC: begin
            state_in = last_ff ? ST_ROOT : ST_IDLE;
         end
         ST_ROOT: begin
            if (root_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mac_en    = 1'b0;
      root_en   = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MAC:  mac_en    = 1'b1;
         ST_ROOT: root_en   = 1'b1;
         ST_DONE: out_load  = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   // dominant dimension tracking
   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = DIMS_BITS'(1);
      end else if (dims_ff > DIMS_BITS'(MAX_DIMS)) begin
         dims_eff = DIMS_BITS'(MAX_DIMS);
      end else begin
         dims_eff = dims_ff;
      end
      c_gt      = req_payload.center_coord > req_payload.point_coord;
      diff      = c_gt ? req_payload.center_coord - req_payload.point_coord
                       : req_payload.point_coord - req_payload.center_coord;
      take      = (coord_count_ff == '0) || (diff > max_abs_diff_ff);
      new_index = take ? coord_count_ff : max_index_ff;
      new_above = take ? c_gt : center_above_ff;
      is_last   = (({1'b0, coord_count_ff} + DIMS_BITS'(1)) >= dims_eff);
      pyr       = new_above ? {1'b0, new_index} : {1'b0, new_index} + dims_eff;
   end

   // shared multiply-accumulate, root step and key assembly
   always_comb begin
      square    = SQUARE_BITS'(diff_ff) * SQUARE_BITS'(diff_ff);
      sum_next  = sum_squares_ff + SUM_BITS'(square);
      rem_shift = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
      trial     = REM_BITS'({root_ff, 2'b01});
      trial_ok  = rem_shift >= trial;
      key       = KEY_BITS'({key_int_ff, {FRAC_BITS{1'b0}}}) + KEY_BITS'(root_ff);
   end

   // register next values
   always_comb begin
      coord_count_in  = coord_count_ff;
      max_abs_diff_in = max_abs_diff_ff;
      max_index_in    = max_index_ff;
      center_above_in = center_above_ff;
      sum_squares_in  = sum_squares_ff;
      diff_in         = diff_ff;
      last_in         = last_ff;
      pyr_in          = pyr_ff;
      key_int_in      = key_int_ff;
      rad_in          = rad_ff;
      rem_in          = rem_ff;
      root_in         = root_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;

      if (req_fire) begin
         diff_in    = diff;
         last_in    = is_last;
         pyr_in     = pyr;
         key_int_in = KEY_INT_BITS'(pyr) * KEY_INT_BITS'(ceil_sqrt(dims_eff));
         if (is_last) begin
            coord_count_in  = '0;
            max_abs_diff_in = '0;
            max_index_in    = '0;
            center_above_in = 1'b0;
         end else begin
            coord_count_in = coord_count_ff + COUNT_BITS'(1);
            if (take) begin
               max_abs_diff_in = diff;
               max_index_in    = new_index;
               center_above_in = new_above;
            end
         end
      end

      if (mac_en) begin
         if (last_ff) begin
            // hand the vector's sum to the root unit, scaled by 2^16
            sum_squares_in = '0;
            rad_in         = {sum_next, {(2 * FRAC_BITS){1'b0}}};
            rem_in         = '0;
            root_in        = '0;
            step_in        = '0;
         end else begin
            sum_squares_in = sum_next;
         end
      end

      if (root_en) begin
         rad_in  = {rad_ff[RAD_BITS-3:0], 2'b00};
         rem_in  = trial_ok ? rem_shift - trial : rem_shift;
         root_in = {root_ff[ROOT_BITS-2:0], trial_ok};
         step_in = step_ff + STEP_BITS'(1);
      end

      if (out_load) begin
         rsp_valid_in                  = 1'b1;
         rsp_payload_in.pyramid_number = pyr_ff;
         rsp_payload_in.key_fixed      = key;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration port
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[CSR_ADDR_BITS-1] == REG_DIMENSIONS)
                      ? CSR_DATA_BITS'(dims_ff) : '0;

   always_comb begin
      dims_in = dims_ff;
      if (csr_write && paddr[CSR_ADDR_BITS-1] == REG_DIMENSIONS) begin
         dims_in = pwdata[DIMS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         dims_ff         <= DIMS_RESET;
         coord_count_ff  <= '0;
         max_abs_diff_ff <= '0;
         max_index_ff    <= '0;
         center_above_ff <= 1'b0;
         sum_squares_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         dims_ff         <= dims_in;
         coord_count_ff  <= coord_count_in;
         max_abs_diff_ff <= max_abs_diff_in;
         max_index_ff    <= max_index_in;
         center_above_ff <= center_above_in;
         sum_squares_ff  <= sum_squares_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff        <= diff_in;
      last_ff        <= last_in;
      pyr_ff         <= pyr_in;
      key_int_ff     <= key_int_in;
      rad_ff         <= rad_in;
      rem_ff         <= rem_in;
      root_ff        <= root_in;
      step_ff        <= step_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // the root unit never runs past its last bit
   a_root_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (step_ff <= STEP_BITS'(ROOT_BITS - 1)))
      else $error("root step counter overran");

   // a vector's last transaction leaves the tracking state cleared
   a_vector_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_last) |=> (coord_count_ff == '0 && max_abs_diff_ff == '0))
      else $error("vector state not cleared after last coordinate");

   // a waiting result is never overwritten by the next one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result loaded while previous result pending");

   // the sum of squares is handed off before the root unit starts
   a_sum_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && last_ff) |=> (state_ff == ST_ROOT && sum_squares_ff == '0))
      else $error("sum of squares not handed to root unit");

endmodule

`default_nettype wire

// ===== bench/tb_pyramid_index_key_unit.sv =====
// -----------------------------------------------------------------------------
// tb_pyramid_index_key_unit
// Streams (center, point) coordinate pairs into the pyramid index key unit,
// predicts the pyramid number and fixed point key of every finished vector,
// and checks each result transaction in order. Directed vectors cover ties,
// all-zero vectors and the dimension clamps. Random phases then sweep the
// dimensions register, with random idling on both channels.
// -----------------------------------------------------------------------------

module tb_pyramid_index_key_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pik_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] DIMS_ADDR = CSR_ADDR_BITS'(4 * REG_DIMENSIONS);
   localparam int MAX_GAP = 18;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS = 600;

   // running pyramid key of the vector in flight, plus the keys still owed
   class pyramid_key_check;
      logic [DIMS_BITS-1:0]  dims_reg;
      logic [COUNT_BITS-1:0] coord_count;
      logic [COORD_BITS-1:0] max_diff;
      logic [COUNT_BITS-1:0] max_index;
      logic                  center_above;
      logic [SUM_BITS-1:0]   sum_sq;
      rsp_payload_type       expected_keys[$];
      int                    errors;

      function new();
         dims_reg = DIMS_RESET;
         errors = 0;
         clear_vector();
      endfunction

      function void clear_vector();
         coord_count = '0;
         max_diff = '0;
         max_index = '0;
         center_above = 1'b0;
         sum_sq = '0;
      endfunction

      // truncated root, one result bit at a time from the top
      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] trial;
         root = '0;
         for (int b = 27; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      function logic [63:0] ceil_root(logic [63:0] n);
         logic [63:0] r;
         r = '0;
         while (r * r < n) r++;
         return r;
      endfunction

      function void take_coords(req_payload_type item);
         logic [63:0]     eff;
         logic [63:0]     diff;
         logic [63:0]     pyr;
         logic [63:0]     key;
         logic            c_gt;
         rsp_payload_type want;
         if (dims_reg == '0) eff = 1;
         else if (dims_reg > MAX_DIMS) eff = MAX_DIMS;
         else eff = 64'(dims_reg);
         c_gt = item.center_coord > item.point_coord;
         diff = c_gt ? 64'(item.center_coord) - 64'(item.point_coord)
                     : 64'(item.point_coord) - 64'(item.center_coord);
         // the first dimension always takes the lead, later ones only when strictly larger
         if (coord_count == '0) begin
            max_diff = diff[COORD_BITS-1:0];
            max_index = '0;
            center_above = c_gt;
         end else if (diff > 64'(max_diff)) begin
            max_diff = diff[COORD_BITS-1:0];
            max_index = coord_count;
            center_above = c_gt;
         end
         sum_sq = sum_sq + SUM_BITS'(diff * diff);
         if (64'(coord_count) + 1 >= eff) begin
            pyr = center_above ? 64'(max_index) : 64'(max_index) + eff;
            pyr = pyr & 64'h7f;
            key = ((pyr * ceil_root(eff)) << FRAC_BITS) + int_sqrt(64'(sum_sq) << 16);
            want.pyramid_number = pyr[PYR_BITS-1:0];
            want.key_fixed = key[KEY_BITS-1:0];
            expected_keys.push_back(want);
            clear_vector();
         end else begin
            coord_count = coord_count + 1'b1;
         end
      endfunction

      task report_mismatch(string msg);
         if (errors < 40) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_key(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_keys.size() == 0) begin
            report_mismatch($sformatf("unexpected result pyr=%0d key=%h",
                                      got.pyramid_number, got.key_fixed));
            return;
         end
         want = expected_keys.pop_front();
         if (got.pyramid_number !== want.pyramid_number)
            report_mismatch($sformatf("pyramid_number got %0d want %0d",
                                      got.pyramid_number, want.pyramid_number));
         if (got.key_fixed !== want.key_fixed)
            report_mismatch($sformatf("key_fixed got %h want %h",
                                      got.key_fixed, want.key_fixed));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   pyramid_key_check key_check;
   bit send_burst = 1'b0;
   bit flood = 1'b0;
   int hold_len = 0;

   pyramid_index_key_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_coords(input logic [COORD_BITS-1:0] c, input logic [COORD_BITS-1:0] p);
      int gap;
      gap = (send_burst || flood) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.center_coord <= c;
      req_payload.point_coord <= p;
      // ready comes from the sequencer state only, so it is settled at the falling edge
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      key_check.take_coords(req_payload);
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
   endtask

   // a pair that does not close its vector may still be in the multiply stage when the queue empties
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (key_check.expected_keys.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dims(input logic [CSR_DATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= DIMS_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      key_check.dims_reg = value[DIMS_BITS-1:0];
      // read back in a fresh setup cycle
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_BITS'(value[DIMS_BITS-1:0]))
         key_check.report_mismatch($sformatf("dimensions read %h want %h",
                                             prdata, value[DIMS_BITS-1:0]));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic take_results();
      int stall;
      bit burst;
      rsp_payload_type got;
      burst = 1'b0;
      forever begin
         if (hold_len > 0) begin
            stall = hold_len;
            hold_len = 0;
         end else begin
            stall = burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // valid and payload are registered, so they hold steady up to the next edge
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         got = rsp_payload;
         @(posedge clock);
         key_check.check_key(got);
         if ($urandom_range(0, 29) == 0) burst = !burst;
      end
   endtask

   initial begin
      int fixed_dims[8];
      int total;
      int phase;
      int n_items;
      int eff;
      int dims_val;
      logic [COORD_BITS-1:0] c;
      logic [COORD_BITS-1:0] p;
      logic [COORD_BITS-1:0] last_diff;

      fixed_dims = '{1, 127, 3, 64, 0, 65, 2, 9};
      key_check = new();
      last_diff = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         take_results();
      join_none

      // reset value of dimensions is two
      send_coords(16'h0000, 16'h0000);
      send_coords(16'h0000, 16'h0000);
      send_coords(16'hffff, 16'h0000);
      send_coords(16'h0000, 16'hffff);
      send_coords(16'h0000, 16'hffff);
      send_coords(16'hffff, 16'h0000);
      send_coords(16'd10, 16'd3);
      send_coords(16'd1, 16'd40);
      send_coords(16'd40, 16'd1);
      send_coords(16'd7, 16'd7);
      wait_idle();
      write_dims(32'd1);
      send_coords(16'hffff, 16'hffff);
      send_coords(16'hffff, 16'h0000);
      send_coords(16'h0000, 16'hffff);
      send_coords(16'h5555, 16'haaaa);
      wait_idle();
      // zero dimensions behave as one
      write_dims(32'd0);
      send_coords(16'haaaa, 16'h5555);
      send_coords(16'd1, 16'd0);
      wait_idle();
      write_dims(32'd5);
      send_coords(16'd3, 16'd1);
      send_coords(16'd9, 16'd2);
      wait_idle();
      // shrink to the count already taken: the next pair closes the vector
      write_dims(32'd2);
      send_coords(16'd4, 16'd4);
      wait_idle();
      write_dims(32'hffff_ff7f);
      send_coords(16'd100, 16'd200);
      send_coords(16'd300, 16'd100);
      send_coords(16'd0, 16'd0);

      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         wait_idle();
         if (phase < 8) dims_val = fixed_dims[phase];
         else if ($urandom_range(0, 3) == 0) dims_val = $urandom_range(0, 127);
         else dims_val = $urandom_range(1, 10);
         write_dims(32'(dims_val) | ($urandom & 32'hffff_ff80));
         eff = (dims_val == 0) ? 1 : (dims_val > MAX_DIMS) ? MAX_DIMS : dims_val;
         n_items = (eff > 16) ? eff + $urandom_range(1, eff) : $urandom_range(15, 50);
         // first phase: hold results off while the sender floods single-pair vectors
         flood = (phase == 0);
         if (phase == 0) hold_len = LONG_HOLD;
         for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 5))
               0: begin
                  c = COORD_BITS'($urandom);
                  p = c;
               end
               1: begin
                  c = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                  p = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
               end
               2: begin
                  c = COORD_BITS'($urandom);
                  p = $urandom_range(0, 1) ? c - last_diff : c + last_diff;
               end
               3: begin
                  c = COORD_BITS'($urandom);
                  p = c + 16'($urandom_range(0, 6)) - 16'd3;
               end
               default: begin
                  c = COORD_BITS'($urandom);
                  p = COORD_BITS'($urandom);
               end
            endcase
            last_diff = (c > p) ? c - p : p - c;
            send_coords(c, p);
         end
         flood = 1'b0;
         total += n_items;
         phase++;
      end

      wait_idle();
      if (key_check.expected_keys.size() != 0)
         key_check.report_mismatch($sformatf("%0d results never arrived",
                                             key_check.expected_keys.size()));
      if (key_check.errors == 0)
         $display("tb_pyramid_index_key_unit: clean");
      else
         $display("tb_pyramid_index_key_unit: errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_pyramid_index_key_unit: errors");
      $finish;
   end

endmodule
